@@ src/atl_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the arithmetic token lexer
// no dependencies

package atl_pkg;

  localparam int VALUE_BITS = 31;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [2:0] kind_t;
  typedef logic [7:0] char_t;

  localparam kind_t K_OPEN   = 3'd0;
  localparam kind_t K_CLOSE  = 3'd1;
  localparam kind_t K_PLUS   = 3'd2;
  localparam kind_t K_MINUS  = 3'd3;
  localparam kind_t K_TIMES  = 3'd4;
  localparam kind_t K_NUMBER = 3'd5;
  localparam kind_t K_ERROR  = 3'd6;
  localparam kind_t K_END    = 3'd7;
  localparam kind_t K_NONE   = 3'd7;

  localparam char_t CH_OPEN  = 8'h28;
  localparam char_t CH_CLOSE = 8'h29;
  localparam char_t CH_TIMES = 8'h2A;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;

  typedef struct packed {
    kind_t  kind;
    value_t value;
    logic   last;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  typedef struct packed {
    logic [QAW:0] used;
  } qstat_t;

endpackage

@@ src/arithmetic_token_lexer.sv @@
`timescale 1ns / 1ps
// top level of the arithmetic token lexer
// depends on atl_pkg, atl_core and atl_outq

// Streaming lexer: one character is taken per cycle and its tokens appear on
// the result channel from the next cycle on. A character yields zero, one or
// two results (a token, an error, either of these followed by the end marker
// on the last character, or the end marker alone). Results pass through a
// four-entry queue, so the input keeps flowing while a result waits;
// in_ready drops only when fewer than two queue slots are free. Sustained
// rate is one character per cycle, bounded by one output result per cycle.

module arithmetic_token_lexer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_char_code,
  input  logic                            in_last_char,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_token_kind,
  output logic [atl_pkg::VALUE_BITS-1:0]  out_token_value,
  output logic                            out_last_result
);
  import atl_pkg::*;

  push_t  push;
  tok_t   head;
  qstat_t stat;
  logic   in_acc;
  logic   pop;

  assign in_ready = (stat.used <= (QAW+1)'(QDEPTH - 2));
  assign in_acc = in_valid && in_ready;
  assign out_valid = (stat.used != '0);
  assign pop = out_valid && out_ready;

  assign out_token_kind = head.kind;
  assign out_token_value = head.value;
  assign out_last_result = head.last;

  atl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .char_code (in_char_code),
    .last_char (in_last_char),
    .push      (push)
  );

  atl_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.used <= (QAW+1)'(QDEPTH))
    else $error("result queue overfilled");

  a_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_char) |=> out_valid)
    else $error("no result after last character");

  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty queue");

  a_push_gated: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |-> (push.cnt == 2'd0))
    else $error("request pushed without accepted character");

endmodule

@@ src/atl_core.sv @@
`timescale 1ns / 1ps
// lexer state registers and per-character token logic
// depends on atl_pkg

module atl_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  atl_pkg::char_t char_code,
  input  logic           last_char,
  output atl_pkg::push_t push
);
  import atl_pkg::*;

  kind_t  pend_r, pend_nxt;
  value_t acc_r, acc_nxt;
  logic   err_r, err_nxt;

  logic               is_space;
  logic [3:0]         digit;
  logic [VALUE_BITS+3:0] prod;
  logic               ovf;

  assign is_space = (char_code == CH_SPACE);
  assign digit = char_code[3:0];
  assign prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
              + {{VALUE_BITS{1'b0}}, digit};
  assign ovf = |prod[VALUE_BITS+3:VALUE_BITS];

  always_comb begin
    logic   a_v;
    kind_t  a_kind;
    value_t a_val;
    a_v = 1'b0;
    a_kind = K_ERROR;
    a_val = '0;
    pend_nxt = pend_r;
    acc_nxt = acc_r;
    err_nxt = err_r;
    push = '0;

    if (!err_r) begin
      if (pend_r == K_NUMBER) begin
        if (char_code inside {[CH_ZERO:CH_NINE]}) begin
          if (ovf) begin
            a_v = 1'b1;
            err_nxt = 1'b1;
            pend_nxt = K_NONE;
            acc_nxt = '0;
          end else begin
            acc_nxt = prod[VALUE_BITS-1:0];
          end
        end else if (is_space) begin
          a_v = 1'b1;
          a_kind = K_NUMBER;
          a_val = acc_r;
          pend_nxt = K_NONE;
          acc_nxt = '0;
        end else begin
          a_v = 1'b1;
          err_nxt = 1'b1;
          pend_nxt = K_NONE;
          acc_nxt = '0;
        end
      end else if (pend_r != K_NONE) begin
        if (is_space) begin
          a_v = 1'b1;
          a_kind = pend_r;
          pend_nxt = K_NONE;
        end else begin
          a_v = 1'b1;
          err_nxt = 1'b1;
          pend_nxt = K_NONE;
          acc_nxt = '0;
        end
      end else if (!is_space) begin
        case (char_code) inside
          CH_OPEN:  pend_nxt = K_OPEN;
          CH_CLOSE: pend_nxt = K_CLOSE;
          CH_PLUS:  pend_nxt = K_PLUS;
          CH_MINUS: pend_nxt = K_MINUS;
          CH_TIMES: pend_nxt = K_TIMES;
          [CH_ZERO:CH_NINE]: begin
            pend_nxt = K_NUMBER;
            acc_nxt = {{(VALUE_BITS-4){1'b0}}, digit};
          end
          default: begin
            a_v = 1'b1;
            err_nxt = 1'b1;
            pend_nxt = K_NONE;
            acc_nxt = '0;
          end
        endcase
      end

      if (last_char && !err_nxt) begin
        if (pend_nxt == K_NUMBER) begin
          a_v = 1'b1;
          a_kind = K_NUMBER;
          a_val = acc_nxt;
        end else if (pend_nxt == K_CLOSE) begin
          a_v = 1'b1;
          a_kind = K_CLOSE;
        end else if (pend_nxt != K_NONE) begin
          a_v = 1'b1;
          a_kind = K_ERROR;
        end
      end
    end

    if (last_char) begin
      pend_nxt = K_NONE;
      acc_nxt = '0;
      err_nxt = 1'b0;
    end

    // token first, end marker second
    if (a_v) begin
      push.t0.kind = a_kind;
      push.t0.value = a_val;
      push.t0.last = !last_char;
      if (last_char) begin
        push.cnt = 2'd2;
        push.t1.kind = K_END;
        push.t1.last = 1'b1;
      end else begin
        push.cnt = 2'd1;
      end
    end else if (last_char) begin
      push.cnt = 2'd1;
      push.t0.kind = K_END;
      push.t0.last = 1'b1;
    end

    if (!accept) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= K_NONE;
      acc_r <= '0;
      err_r <= 1'b0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      acc_r <= acc_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

@@ src/atl_outq.sv @@
`timescale 1ns / 1ps
// result queue, takes up to two tokens a cycle and hands out one
// depends on atl_pkg

module atl_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  atl_pkg::push_t push,
  input  logic           pop,
  output atl_pkg::tok_t  head,
  output atl_pkg::qstat_t stat
);
  import atl_pkg::*;

  tok_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   used_r, used_nxt;
  logic [QAW-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + QAW'(1);
  assign wr_ptr_nxt = wr_ptr_r + QAW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + QAW'(pop);
  assign used_nxt = used_r + (QAW+1)'(push.cnt) - (QAW+1)'(pop);

  assign head = mem_r[rd_ptr_r];
  assign stat.used = used_r;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.t0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.t1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      used_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      used_r <= used_nxt;
    end
  end

endmodule
